FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL. Full checks in simulation,
// empty bodies when building for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(name, clk, rstn, prop)
`define ASSERT_IMPLY(name, clk, rstn, pre, post)
`endif
`endif

FILE: rtl/srad_pkg.sv
// ---------------------------------------------------------------------------
// srad_pkg
// Types, constants and field layout shared by the source rate detector.
// ---------------------------------------------------------------------------
`default_nettype none
package srad_pkg;

    // table size default
    localparam int TABLE_ENTRIES_DEF = 64;

    // register reset values
    localparam logic [15:0] SCAN_THR_RST   = 16'd100;
    localparam logic [15:0] FLOOD_THR_RST  = 16'd100;
    localparam logic [15:0] SSH_THR_RST    = 16'd4;
    localparam logic [15:0] WINDOW_RST     = 16'd10;
    localparam logic [15:0] SSH_PORT_RST   = 16'd22;

    // configuration register indexes
    localparam int          CFG_IDX_W      = 3;
    localparam logic [2:0]  CFG_SCAN_THR   = 3'd0;
    localparam logic [2:0]  CFG_FLOOD_THR  = 3'd1;
    localparam logic [2:0]  CFG_SSH_THR    = 3'd2;
    localparam logic [2:0]  CFG_WINDOW     = 3'd3;
    localparam logic [2:0]  CFG_SSH_PORT   = 3'd4;

    // packet kinds
    localparam logic [1:0]  KIND_TCP       = 2'd0;
    localparam logic [1:0]  KIND_UDP       = 2'd1;
    localparam logic [1:0]  KIND_ICMP      = 2'd2;

    // input tdata layout
    localparam int IN_DATA_W  = 104;
    localparam int POS_SRC    = 0;
    localparam int POS_SYN    = 32;
    localparam int POS_ACK    = 33;
    localparam int POS_FIN    = 34;
    localparam int POS_URG    = 35;
    localparam int POS_PSH    = 36;
    localparam int POS_PORT   = 37;
    localparam int POS_MF     = 53;
    localparam int POS_OFF    = 54;
    localparam int POS_NOW    = 67;

    // result bit positions
    localparam int OUT_DATA_W = 8;
    localparam int RES_W      = 7;
    localparam int RES_XMAS   = 0;
    localparam int RES_SCAN   = 1;
    localparam int RES_SSH    = 2;
    localparam int RES_UDP    = 3;
    localparam int RES_ICMP   = 4;
    localparam int RES_FRAG   = 5;
    localparam int RES_FULL   = 6;

    // command queue
    localparam int QPTR_W      = 1;
    localparam int QUEUE_DEPTH = 2 ** QPTR_W;

    typedef enum logic [1:0] {
        ALERT_SCAN,
        ALERT_SSH,
        ALERT_UDP,
        ALERT_ICMP
    } alert_sel_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] now;
        logic [15:0] thr;
        alert_sel_t  sel;
        logic        touch;
        logic        xmas;
        logic        frag;
    } cmd_t;

    // one table entry
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] count;
        logic [31:0] last;
    } entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_CHECK,
        B_UPDATE,
        B_DONE
    } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/srad_front.sv
// ---------------------------------------------------------------------------
// srad_front
// Accepts packet headers, classifies them and holds one classified request.
// ---------------------------------------------------------------------------
`default_nettype none
module srad_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [srad_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [1:0]                    s_tuser,
    input  wire logic [15:0]                   scan_thr,
    input  wire logic [15:0]                   flood_thr,
    input  wire logic [15:0]                   ssh_thr,
    input  wire logic [15:0]                   ssh_port,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output srad_pkg::cmd_t                     push_cmd
);
    import srad_pkg::*;

    logic hold_valid_reg, hold_valid_next;
    cmd_t cmd_reg, cmd_next;

    logic        syn, ack, fin, urg, psh, mf;
    logic [15:0] port;
    logic [12:0] off;

    assign syn  = s_tdata[POS_SYN];
    assign ack  = s_tdata[POS_ACK];
    assign fin  = s_tdata[POS_FIN];
    assign urg  = s_tdata[POS_URG];
    assign psh  = s_tdata[POS_PSH];
    assign mf   = s_tdata[POS_MF];
    assign port = s_tdata[POS_PORT +: 16];
    assign off  = s_tdata[POS_OFF +: 13];

    // classify the incoming header
    always_comb
    begin
        cmd_next       = '0;
        cmd_next.src   = s_tdata[POS_SRC +: 32];
        cmd_next.now   = s_tdata[POS_NOW +: 32];
        cmd_next.sel   = ALERT_SCAN;
        case (s_tuser)
            KIND_TCP:
            begin
                cmd_next.xmas = fin & urg & psh;
                if (syn && !ack)
                begin
                    cmd_next.touch = 1'b1;
                    cmd_next.sel   = ALERT_SCAN;
                    cmd_next.thr   = scan_thr;
                end
                else if (port == ssh_port)
                begin
                    cmd_next.touch = 1'b1;
                    cmd_next.sel   = ALERT_SSH;
                    cmd_next.thr   = ssh_thr;
                end
            end
            KIND_UDP:
            begin
                cmd_next.touch = 1'b1;
                cmd_next.sel   = ALERT_UDP;
                cmd_next.thr   = flood_thr;
            end
            KIND_ICMP:
            begin
                cmd_next.frag  = mf | (off != 13'd0);
                cmd_next.touch = ~cmd_next.frag;
                cmd_next.sel   = ALERT_ICMP;
                cmd_next.thr   = flood_thr;
            end
            default:
            begin
                cmd_next.touch = 1'b0;
            end
        endcase
    end

    // hold stage
    assign s_tready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = cmd_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (s_tready)
        begin
            hold_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/srad_queue.sv
// ---------------------------------------------------------------------------
// srad_queue
// Short FIFO of classified requests between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none
module srad_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire srad_pkg::cmd_t push_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output srad_pkg::cmd_t      pop_cmd
);
    import srad_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/srad_back.sv
// ---------------------------------------------------------------------------
// srad_back
// Source table: linear search, window/count update, insert, result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module srad_back #(
    parameter int TABLE_ENTRIES = srad_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pop_valid,
    output logic                                 pop_ready,
    input  wire srad_pkg::cmd_t                  pop_cmd,
    input  wire logic [15:0]                     window,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [srad_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import srad_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;

    back_state_t      state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [RES_W-1:0] res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    logic [RES_W-1:0] out_data_reg;
    entry_t           rd_data_reg;
    entry_t           mem [TABLE_ENTRIES];

    logic             we;
    logic [IDX_W-1:0] wa;
    entry_t           wd;

    logic             match, last_idx, is_full, out_free;
    logic             expired, hit;
    logic [32:0]      deadline;
    logic [15:0]      new_count;

    assign match    = rd_data_reg.addr == cmd_reg.src;
    assign last_idx = ({1'b0, idx_reg} + 1'b1) == used_reg;
    assign is_full  = used_reg == CNT_W'(TABLE_ENTRIES);
    assign out_free = !out_valid_reg || m_tready;

    // window test and saturating count
    assign deadline  = {1'b0, rd_data_reg.last} + {17'd0, window};
    assign expired   = deadline < {1'b0, cmd_reg.now};
    assign new_count = expired ? 16'd1 :
                       (rd_data_reg.count != 16'hFFFF) ? rd_data_reg.count + 16'd1 :
                       rd_data_reg.count;
    assign hit       = !expired && (new_count >= cmd_reg.thr);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    if (!pop_cmd.touch || used_reg == '0)
                    begin
                        state_next = B_DONE;
                    end
                    else
                    begin
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (match)
                begin
                    state_next = B_UPDATE;
                end
                else if (last_idx)
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_READ;
                end
            end
            B_UPDATE:
            begin
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop_ready      = 1'b0;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        we             = 1'b0;
        wa             = used_reg[IDX_W-1:0];
        wd.addr        = cmd_reg.src;
        wd.count       = 16'd1;
        wd.last        = cmd_reg.now;
        case (state_reg)
            B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    cmd_next           = pop_cmd;
                    idx_next           = '0;
                    res_next           = '0;
                    res_next[RES_XMAS] = pop_cmd.xmas;
                    res_next[RES_FRAG] = pop_cmd.frag;
                    // empty table: insert at slot zero at once
                    if (pop_cmd.touch && used_reg == '0)
                    begin
                        we        = 1'b1;
                        wa        = '0;
                        wd.addr   = pop_cmd.src;
                        wd.last   = pop_cmd.now;
                        used_next = used_reg + 1'b1;
                    end
                end
            end
            B_CHECK:
            begin
                if (!match)
                begin
                    if (last_idx)
                    begin
                        // source not present: insert or flag
                        if (is_full)
                        begin
                            res_next[RES_FULL] = 1'b1;
                        end
                        else
                        begin
                            we        = 1'b1;
                            used_next = used_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            B_UPDATE:
            begin
                we       = 1'b1;
                wa       = idx_reg;
                wd.count = new_count;
                case (cmd_reg.sel)
                    ALERT_SCAN: res_next[RES_SCAN] = hit;
                    ALERT_SSH:  res_next[RES_SSH]  = hit;
                    ALERT_UDP:  res_next[RES_UDP]  = hit;
                    ALERT_ICMP: res_next[RES_ICMP] = hit;
                    default:    res_next[RES_SCAN] = 1'b0;
                endcase
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        if (state_reg == B_DONE && out_free)
        begin
            out_data_reg <= res_reg;
        end
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_data_reg};

    `ASSERT_CLK(a_used_bound, clk, rst_n, used_reg <= CNT_W'(TABLE_ENTRIES))
    `ASSERT_IMPLY(a_pop_idle, clk, rst_n, pop_valid && pop_ready, state_reg == B_IDLE)
    `ASSERT_IMPLY(a_update_match, clk, rst_n, state_reg == B_UPDATE, rd_data_reg.addr == cmd_reg.src)
    `ASSERT_IMPLY(a_search_range, clk, rst_n, state_reg == B_CHECK, {1'b0, idx_reg} < used_reg)

endmodule
`default_nettype wire

FILE: rtl/source_rate_attack_detector_core.sv
// Search: each table entry searched passes a read state and a check state (one
// memory read port, read data registered); an item also passes the front hold
// register, the queue and the result register.
// Throughput: one item at a time in the table stage; the front and queue
// accept up to three more while it works.
// Reset: rst_n asynchronous, clears control state and fill count, loads config registers.
// ---------------------------------------------------------------------------
// source_rate_attack_detector_core
// Per-source packet rate detector: header classification, source table,
// threshold alerts.
// ---------------------------------------------------------------------------
`default_nettype none
module source_rate_attack_detector_core #(
    parameter int TABLE_ENTRIES = srad_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // tdata: src_addr, flag_syn, flag_ack, flag_fin, flag_urg, flag_psh,
    //        dest_port, more_fragments, fragment_offset, now_seconds
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [srad_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]                      s_tuser,   // kind
    // tdata: alert_xmas, alert_port_scan, alert_ssh_brute, alert_udp_flood,
    //        alert_icmp_flood, alert_icmp_fragment, table_full
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [srad_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [srad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [15:0]                     cfg_data
);
    import srad_pkg::*;

    logic [15:0] scan_thr_reg, flood_thr_reg, ssh_thr_reg, window_reg, ssh_port_reg;
    logic        push_valid, push_ready, pop_valid, pop_ready;
    cmd_t        push_cmd, pop_cmd;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_thr_reg  <= SCAN_THR_RST;
            flood_thr_reg <= FLOOD_THR_RST;
            ssh_thr_reg   <= SSH_THR_RST;
            window_reg    <= WINDOW_RST;
            ssh_port_reg  <= SSH_PORT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCAN_THR:  scan_thr_reg  <= cfg_data;
                CFG_FLOOD_THR: flood_thr_reg <= cfg_data;
                CFG_SSH_THR:   ssh_thr_reg   <= cfg_data;
                CFG_WINDOW:    window_reg    <= cfg_data;
                CFG_SSH_PORT:  ssh_port_reg  <= cfg_data;
                default:       scan_thr_reg  <= scan_thr_reg;
            endcase
        end
    end

    srad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .scan_thr   (scan_thr_reg),
        .flood_thr  (flood_thr_reg),
        .ssh_thr    (ssh_thr_reg),
        .ssh_port   (ssh_port_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    srad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    srad_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .window    (window_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

FILE: bench/source_rate_attack_detector_checker.sv
// ---------------------------------------------------------------------------
// source_rate_attack_detector_checker
// Watches the packet, alert and register channels of the detector, keeps its
// own copy of the source table and settings, predicts the alert bits of each
// packet request and compares every result request with the oldest one due.
// ---------------------------------------------------------------------------
`default_nettype none
module source_rate_attack_detector_checker #(
    parameter int TABLE_ENTRIES = srad_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [srad_pkg::IN_DATA_W-1:0]   s_tdata,
    input  wire logic [1:0]                       s_tuser,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [srad_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [srad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [15:0]                      cfg_data,
    output int                                    fail_count,
    output int                                    alerts_pending
);
    import srad_pkg::*;

    // settings copy
    logic [15:0] scan_thr;
    logic [15:0] flood_thr;
    logic [15:0] ssh_thr;
    logic [15:0] window_len;
    logic [15:0] ssh_dport;

    // source table copy
    logic [31:0] src_addr [TABLE_ENTRIES];
    logic [15:0] src_count [TABLE_ENTRIES];
    logic [31:0] src_seen [TABLE_ENTRIES];
    int          sources_used;

    logic [RES_W-1:0] alerts_due [$];

    string bit_names [RES_W] = '{"alert_xmas", "alert_port_scan", "alert_ssh_brute",
        "alert_udp_flood", "alert_icmp_flood", "alert_icmp_fragment", "table_full"};

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // update or insert one source's entry; returns 1 when a known, unexpired source reaches its threshold
    function automatic logic touch_source(input logic [31:0] addr, input logic [31:0] now,
                                          input logic [15:0] thr, inout logic full);
        logic [32:0] limit;
        for (int i = 0; i < sources_used; i++)
        begin
            if (src_addr[i] == addr)
            begin
                limit = {1'b0, src_seen[i]} + {17'd0, window_len};
                src_seen[i] = now;
                if (limit < {1'b0, now})
                begin
                    src_count[i] = 16'd1;
                    return 1'b0;
                end
                if (src_count[i] != 16'hFFFF)
                    src_count[i] = src_count[i] + 16'd1;
                return src_count[i] >= thr;
            end
        end
        if (sources_used >= TABLE_ENTRIES)
        begin
            full = 1'b1;
            return 1'b0;
        end
        src_addr[sources_used]  = addr;
        src_count[sources_used] = 16'd1;
        src_seen[sources_used]  = now;
        sources_used++;
        return 1'b0;
    endfunction

    // alert bits of one packet
    function automatic logic [RES_W-1:0] predict_alerts(input logic [1:0] kind,
                                                        input logic [IN_DATA_W-1:0] hdr);
        logic [RES_W-1:0] res;
        logic             full;
        logic [31:0]      src;
        logic [31:0]      now;
        logic [15:0]      port;
        res  = '0;
        full = 1'b0;
        src  = hdr[POS_SRC +: 32];
        now  = hdr[POS_NOW +: 32];
        port = hdr[POS_PORT +: 16];
        if (kind == KIND_TCP)
        begin
            res[RES_XMAS] = hdr[POS_FIN] & hdr[POS_URG] & hdr[POS_PSH];
            if (hdr[POS_SYN] && !hdr[POS_ACK])
                res[RES_SCAN] = touch_source(src, now, scan_thr, full);
            else if (port == ssh_dport)
                res[RES_SSH] = touch_source(src, now, ssh_thr, full);
        end
        else if (kind == KIND_UDP)
            res[RES_UDP] = touch_source(src, now, flood_thr, full);
        else if (kind == KIND_ICMP)
        begin
            if (hdr[POS_MF] || hdr[POS_OFF +: 13] != 13'd0)
                res[RES_FRAG] = 1'b1;
            else
                res[RES_ICMP] = touch_source(src, now, flood_thr, full);
        end
        res[RES_FULL] = full;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [RES_W-1:0] want;
        if (!rst_n)
        begin
            scan_thr       <= SCAN_THR_RST;
            flood_thr      <= FLOOD_THR_RST;
            ssh_thr        <= SSH_THR_RST;
            window_len     <= WINDOW_RST;
            ssh_dport      <= SSH_PORT_RST;
            sources_used   = 0;
            fail_count     = 0;
            alerts_due.delete();
            alerts_pending = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCAN_THR:  scan_thr   <= cfg_data;
                    CFG_FLOOD_THR: flood_thr  <= cfg_data;
                    CFG_SSH_THR:   ssh_thr    <= cfg_data;
                    CFG_WINDOW:    window_len <= cfg_data;
                    CFG_SSH_PORT:  ssh_dport  <= cfg_data;
                    default: ;
                endcase
            end
            // packet requests
            if (s_tvalid && s_tready)
                alerts_due.push_back(predict_alerts(s_tuser, s_tdata));
            // result requests
            if (m_tvalid && m_tready)
            begin
                if (alerts_due.size() == 0)
                    report_mismatch($sformatf("unexpected result %b", m_tdata));
                else
                begin
                    want = alerts_due.pop_front();
                    for (int b = 0; b < RES_W; b++)
                        if (m_tdata[b] !== want[b])
                            report_mismatch($sformatf("%s got %b want %b",
                                bit_names[b], m_tdata[b], want[b]));
                    if (m_tdata[OUT_DATA_W-1] !== 1'b0)
                        report_mismatch("pad bit not zero");
                end
            end
            alerts_pending = alerts_due.size();
        end
    end

endmodule
`default_nettype wire

FILE: bench/source_rate_attack_detector_core_tb.sv
// ---------------------------------------------------------------------------
// source_rate_attack_detector_core_tb
// Drives packet headers and register writes into the detector with random
// gaps and output stalls; the checker predicts and compares the alerts.
// ---------------------------------------------------------------------------
`default_nettype none
module source_rate_attack_detector_core_tb;
    import srad_pkg::*;

    localparam int  TABLE_SIZE  = TABLE_ENTRIES_DEF;
    localparam int  DRAIN_WAIT  = 2 * TABLE_SIZE + 40;
    localparam longint CYCLE_LIMIT = 2_000_000;

    // kind with no protocol, register index with no register
    localparam logic [1:0]           KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;    // src, syn, ack, fin, urg, psh, port, mf, off, now
    logic [1:0]             s_tuser;    // kind
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;    // xmas, scan, ssh, udp, icmp, frag, full
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [15:0]            cfg_data;
    int                     fail_count;
    int                     alerts_pending;
    longint                 cycle_count;
    logic                   stall_on;

    // source pool and clock for well-formed bursts
    logic [31:0] src_pool [8];
    logic [31:0] clock_sec;

    source_rate_attack_detector_core #(.TABLE_ENTRIES(TABLE_SIZE)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    source_rate_attack_detector_checker #(.TABLE_ENTRIES(TABLE_SIZE)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .alerts_pending(alerts_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // timeout
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver stalls: random wait before each result, some stretches without
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = stall_on ? $urandom_range(0, 17) : 0;
            m_tready = 1'b0;
            repeat (gap) @(negedge clk);
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // one packet request, called at a falling edge
    task automatic send_packet(input logic [1:0] kind, input logic [31:0] src,
                               input logic [4:0] flags, input logic [15:0] port,
                               input logic mf, input logic [12:0] off,
                               input logic [31:0] now);
        int gap;
        gap = stall_on ? $urandom_range(0, 17) : 0;
        repeat (gap) @(negedge clk);
        s_tuser  = kind;
        s_tdata  = IN_DATA_W'({now, off, mf, port, flags[4], flags[3], flags[2], flags[1],
                               flags[0], src});
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // let the block drain before touching registers
    task automatic wait_idle();
        while (alerts_pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_all(input logic [15:0] scan, input logic [15:0] flood,
                           input logic [15:0] ssh, input logic [15:0] win,
                           input logic [15:0] port);
        wait_idle();
        write_reg(CFG_SCAN_THR, scan);
        write_reg(CFG_FLOOD_THR, flood);
        write_reg(CFG_SSH_THR, ssh);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_SSH_PORT, port);
    endtask

    // random packet: mostly well-formed attack bursts on a small source pool
    task automatic random_packet(input logic [15:0] sshp);
        logic [1:0]  kind;
        logic [31:0] src;
        logic [4:0]  flags;
        logic [15:0] port;
        logic        mf;
        logic [12:0] off;
        int          pick;
        pick = $urandom_range(0, 99);
        src  = src_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 9) == 0)
            src = $urandom;
        // time mostly creeps forward, sometimes jumps or runs back
        case ($urandom_range(0, 9))
            0: clock_sec = clock_sec + $urandom_range(0, 40);
            1: clock_sec = clock_sec - $urandom_range(0, 5);
            2: clock_sec = $urandom;
            default: clock_sec = clock_sec + $urandom_range(0, 1);
        endcase
        flags = 5'($urandom);
        port  = 16'($urandom);
        mf    = 1'b0;
        off   = '0;
        if (pick < 30)
        begin
            kind = KIND_TCP;
            flags[1:0] = 2'b01;   // SYN without ACK
        end
        else if (pick < 50)
        begin
            kind = KIND_TCP;
            port = sshp;
            flags[0] = $urandom_range(0, 3) == 0;
        end
        else if (pick < 65)
            kind = KIND_UDP;
        else if (pick < 80)
            kind = KIND_ICMP;
        else
        begin
            kind = 2'($urandom_range(0, 3));
            mf   = 1'($urandom);
            off  = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'($urandom);
        end
        send_packet(kind, src, flags, port, mf, off, clock_sec);
    endtask

    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_TCP;
        cfg_valid = 1'b0;
        cfg_index = CFG_SCAN_THR;
        cfg_data  = '0;
        stall_on  = 1'b1;
        clock_sec = 32'd1000;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < 8; i++)
            src_pool[i] = (i == 0) ? 32'hFFFF_FFFF : ((i == 1) ? 32'h0 : $urandom);

        // directed: reset settings, ssh threshold 4
        for (int i = 0; i < 5; i++)
            send_packet(KIND_TCP, 32'h0A00_0001, 5'b00000, 16'd22, 1'b0, 13'd0, 32'd5);
        send_packet(KIND_TCP, 32'h0A00_0001, 5'b00001, 16'd22, 1'b0, 13'd0, 32'd6);
        send_packet(KIND_TCP, 32'hFFFF_FFFF, 5'b11100, 16'hFFFF, 1'b1, 13'h1FFF, 32'hFFFF_FFFF);
        send_packet(KIND_TCP, 32'h0A00_0002, 5'b00010, 16'd80, 1'b0, 13'd0, 32'd7);
        send_packet(KIND_ICMP, 32'h0A00_0003, 5'b0, 16'd0, 1'b1, 13'd0, 32'd7);
        send_packet(KIND_ICMP, 32'h0A00_0003, 5'b0, 16'd0, 1'b0, 13'h1FFF, 32'd7);
        send_packet(KIND_ICMP, 32'h0A00_0003, 5'b0, 16'd0, 1'b0, 13'd0, 32'd7);
        send_packet(KIND_UNUSED, 32'h0A00_0004, 5'b11111, 16'd22, 1'b1, 13'd1, 32'd7);
        // window expiry, then time running back, with threshold 1
        set_all(16'd1, 16'd1, 16'd1, 16'd0, 16'hFFFF);
        send_packet(KIND_UDP, 32'h0A00_0005, 5'b0, 16'd0, 1'b0, 13'd0, 32'd100);
        send_packet(KIND_UDP, 32'h0A00_0005, 5'b0, 16'd0, 1'b0, 13'd0, 32'd100);
        send_packet(KIND_UDP, 32'h0A00_0005, 5'b0, 16'd0, 1'b0, 13'd0, 32'd101);
        send_packet(KIND_UDP, 32'h0A00_0005, 5'b0, 16'd0, 1'b0, 13'd0, 32'd50);
        send_packet(KIND_TCP, 32'h0A00_0006, 5'b0, 16'hFFFF, 1'b0, 13'd0, 32'd0);
        send_packet(KIND_TCP, 32'h0A00_0006, 5'b0, 16'hFFFF, 1'b0, 13'd0, 32'd0);
        // long window from near the top of time; zero thresholds, unused index
        set_all(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
        write_reg(CFG_UNUSED, 16'h1234);
        send_packet(KIND_ICMP, 32'h0A00_0007, 5'b0, 16'd0, 1'b0, 13'd0, 32'hFFFF_FFF0);
        send_packet(KIND_ICMP, 32'h0A00_0007, 5'b0, 16'd0, 1'b0, 13'd0, 32'hFFFF_FFFF);
        send_packet(KIND_TCP, 32'h0A00_0008, 5'b00000, 16'd0, 1'b0, 13'd0, 32'd1);

        // random phases over several settings
        for (int phase = 0; phase < 6; phase++)
        begin
            logic [15:0] sshp;
            sshp = (phase == 5) ? 16'hFFFF : 16'($urandom_range(0, 3000));
            stall_on = (phase != 2);
            case (phase)
                0: set_all(16'd3, 16'd5, 16'd2, 16'd3, sshp);
                1: set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, sshp);
                2: set_all(16'd1, 16'd2, 16'd3, 16'd20, sshp);
                default: set_all(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                                 16'($urandom_range(1, 8)), 16'($urandom_range(0, 30)), sshp);
            endcase
            for (int n = 0; n < 72; n++)
                random_packet(sshp);
        end
        // fill the table and beyond with fresh sources
        for (int n = 0; n < 80; n++)
            send_packet(KIND_UDP, $urandom, 5'b0, 16'd0, 1'b0, 13'd0, clock_sec);
        for (int n = 0; n < 20; n++)
            random_packet(16'd22);

        while (alerts_pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
